// ===== design/cpp_pkg.sv =====
// Package for the clipped point projection unit.
// Holds field widths, screen defaults, the clip margin, status codes, register indexes and reset values.
// No dependencies.
package cpp_pkg;

  localparam int COORD_W   = 16;
  localparam int PIXEL_X_W = 9;
  localparam int PIXEL_Y_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 200;

  // Plane test margin of 1/32 at scale 2^18.
  localparam logic signed [33:0] CLIP_MARGIN = 34'sd8192;

  typedef enum logic [2:0] {
    ST_DRAWN     = 3'd0,
    ST_LEFT      = 3'd1,
    ST_RIGHT     = 3'd2,
    ST_BEHIND    = 3'd3,
    ST_OFFSCREEN = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_PLANE  = 3'd0,
    REG_RIGHT_PLANE = 3'd1,
    REG_ROTATION    = 3'd2,
    REG_CAMERA_POS  = 3'd3,
    REG_FOCAL_DIST  = 3'd4
  } reg_idx_t;

  localparam logic [47:0] LEFT_PLANE_RST  = 48'h0;
  localparam logic [47:0] RIGHT_PLANE_RST = 48'h0;
  localparam logic [63:0] ROTATION_RST    = 64'h4000_0000_0000_4000;
  localparam logic [47:0] CAMERA_POS_RST  = 48'h0;
  localparam logic [15:0] FOCAL_DIST_RST  = 16'd2560;

endpackage

// ===== design/cpp_in_if.sv =====
// Input channel carrying one world point per item.
// Depends on cpp_pkg.
interface cpp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cpp_pkg::COORD_W-1:0]   point_x;
  logic signed [cpp_pkg::COORD_W-1:0]   point_height;
  logic signed [cpp_pkg::COORD_W-1:0]   point_z;

  modport source (output valid, point_x, point_height, point_z, input ready);
  modport sink   (input valid, point_x, point_height, point_z, output ready);
endinterface

// ===== design/cpp_out_if.sv =====
// Result channel carrying status and pixel position per item.
// Depends on cpp_pkg.
interface cpp_out_if;
  logic                              valid;
  logic                              ready;
  cpp_pkg::status_t                  status;
  logic [cpp_pkg::PIXEL_X_W-1:0]     pixel_x;
  logic [cpp_pkg::PIXEL_Y_W-1:0]     pixel_y;

  modport source (output valid, status, pixel_x, pixel_y, input ready);
  modport sink   (input valid, status, pixel_x, pixel_y, output ready);
endinterface

// ===== design/cpp_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on cpp_pkg.
interface cpp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cpp_pkg::CFG_IDX_W-1:0]     index;
  logic [cpp_pkg::CFG_DAT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/clipped_point_projection_unit.sv =====
// Clipped point projection unit. One world point enters per cycle while out_ch does not
// stall it, and passes the plane test, rotation, numerator and overflow-check stages,
// then a restoring divider with one quotient bit per stage, and an output register. The
// whole pipeline holds while a result waits on out_ch, and configuration writes are always
// taken, to be made only while no item is in flight.
module clipped_point_projection_unit #(
  parameter int SCREEN_WIDTH  = cpp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = cpp_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cpp_in_if.sink     in_ch,
  cpp_out_if.source  out_ch,
  cpp_cfg_if.sink    cfg_ch
);

  // Quotient widths hold the screen size itself, so the bound compare never wraps.
  localparam int QXB = $clog2(SCREEN_WIDTH + 1);
  localparam int QYB = $clog2(SCREEN_HEIGHT + 1);
  localparam int QM  = (QXB > QYB) ? QXB : QYB;
  localparam int MXB = (SCREEN_WIDTH > SCREEN_HEIGHT) ? QXB : QYB;
  localparam int RW  = 35;
  localparam int NW  = RW + 19 + MXB;
  localparam int UW  = NW + QM;
  localparam int NST = 4 + QM;

  localparam logic signed [NW-1:0] KX   = NW'(8 * SCREEN_WIDTH);
  localparam logic signed [NW-1:0] KY   = NW'(SCREEN_HEIGHT);
  localparam logic signed [NW-1:0] K2K  = NW'(2048);
  localparam logic [QM-1:0]        QW   = QM'(SCREEN_WIDTH);
  localparam logic [QM-1:0]        QH   = QM'(SCREEN_HEIGHT);

  // Configuration registers.
  logic [47:0] left_plane_r, right_plane_r, camera_pos_r;
  logic [63:0] rotation_r;
  logic [15:0] focal_dist_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_plane_r  <= cpp_pkg::LEFT_PLANE_RST;
      right_plane_r <= cpp_pkg::RIGHT_PLANE_RST;
      rotation_r    <= cpp_pkg::ROTATION_RST;
      camera_pos_r  <= cpp_pkg::CAMERA_POS_RST;
      focal_dist_r  <= cpp_pkg::FOCAL_DIST_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        cpp_pkg::REG_LEFT_PLANE:  left_plane_r  <= cfg_ch.data[47:0];
        cpp_pkg::REG_RIGHT_PLANE: right_plane_r <= cfg_ch.data[47:0];
        cpp_pkg::REG_ROTATION:    rotation_r    <= cfg_ch.data;
        cpp_pkg::REG_CAMERA_POS:  camera_pos_r  <= cfg_ch.data[47:0];
        cpp_pkg::REG_FOCAL_DIST:  focal_dist_r  <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] lnx, lnz, ldst, rnx, rnz, rdst;
  logic signed [15:0] m00, m01, m10, m11, cx, cz, calt;
  logic signed [16:0] fs;

  assign lnx  = $signed(left_plane_r[15:0]);
  assign lnz  = $signed(left_plane_r[31:16]);
  assign ldst = $signed(left_plane_r[47:32]);
  assign rnx  = $signed(right_plane_r[15:0]);
  assign rnz  = $signed(right_plane_r[31:16]);
  assign rdst = $signed(right_plane_r[47:32]);
  assign m00  = $signed(rotation_r[15:0]);
  assign m01  = $signed(rotation_r[31:16]);
  assign m10  = $signed(rotation_r[47:32]);
  assign m11  = $signed(rotation_r[63:48]);
  assign cx   = $signed(camera_pos_r[15:0]);
  assign cz   = $signed(camera_pos_r[31:16]);
  assign calt = $signed(camera_pos_r[47:32]);
  assign fs   = $signed({1'b0, focal_dist_r});

  // The whole pipeline advances together when the output slot is free.
  logic en;
  logic out_valid_r;
  logic [NST-1:0] v_r;

  assign en          = ~out_valid_r | out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_ch.valid};
    end
  end

  // Stage 1: plane dot products and camera-relative coordinates.
  logic signed [33:0] lsum_nxt, rsum_nxt, lsum_r, rsum_r;
  logic signed [16:0] dx_r, dz_r, hy_r;

  assign lsum_nxt = lnx * in_ch.point_x + lnz * in_ch.point_z - ldst * 34'sd16384;
  assign rsum_nxt = rnx * in_ch.point_x + rnz * in_ch.point_z - rdst * 34'sd16384;

  always_ff @(posedge clk) begin
    if (en) begin
      lsum_r <= lsum_nxt;
      rsum_r <= rsum_nxt;
      dx_r   <= in_ch.point_x - cx;
      dz_r   <= in_ch.point_z - cz;
      hy_r   <= in_ch.point_height - calt;
    end
  end

  // Stage 2: plane verdict and rotation.
  cpp_pkg::status_t   st2_r;
  logic signed [RW-1:0] r2_r, d2_r;
  logic signed [16:0]   hy2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (lsum_r < cpp_pkg::CLIP_MARGIN) begin
        st2_r <= cpp_pkg::ST_LEFT;
      end else if (rsum_r < cpp_pkg::CLIP_MARGIN) begin
        st2_r <= cpp_pkg::ST_RIGHT;
      end else begin
        st2_r <= cpp_pkg::ST_DRAWN;
      end
      r2_r  <= m00 * dx_r + m01 * dz_r;
      d2_r  <= m10 * dx_r + m11 * dz_r;
      hy2_r <= hy_r;
    end
  end

  // Stage 3: depth check, numerators as sign and magnitude, denominators.
  logic signed [NW-1:0] numx, numy;
  cpp_pkg::status_t     st3_r;
  logic [NW-1:0]        absx_r, absy_r, denx_r, deny_r;
  logic                 negx_r, negy_r;

  assign numx = KX * d2_r - fs * r2_r;
  assign numy = KY * d2_r - K2K * fs * hy2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (st2_r == cpp_pkg::ST_DRAWN && d2_r <= 0) begin
        st3_r <= cpp_pkg::ST_BEHIND;
      end else begin
        st3_r <= st2_r;
      end
      negx_r <= numx[NW-1];
      negy_r <= numy[NW-1];
      absx_r <= numx[NW-1] ? $unsigned(-numx) : $unsigned(numx);
      absy_r <= numy[NW-1] ? $unsigned(-numy) : $unsigned(numy);
      denx_r <= $unsigned(NW'(d2_r)) << 4;
      deny_r <= $unsigned(NW'(d2_r)) << 1;
    end
  end

  // Stage 4 onward: overflow check, then one quotient bit per stage.
  cpp_pkg::status_t st_r   [QM+1];
  logic [UW-1:0]    remx_r [QM+1];
  logic [UW-1:0]    remy_r [QM+1];
  logic [UW-1:0]    dnx_r  [QM+1];
  logic [UW-1:0]    dny_r  [QM+1];
  logic [QM-1:0]    qx_r   [QM+1];
  logic [QM-1:0]    qy_r   [QM+1];
  logic             ngx_r  [QM+1];
  logic             ngy_r  [QM+1];
  logic             ovx_r  [QM+1];
  logic             ovy_r  [QM+1];

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]   <= st3_r;
      remx_r[0] <= UW'(absx_r);
      remy_r[0] <= UW'(absy_r);
      dnx_r[0]  <= UW'(denx_r);
      dny_r[0]  <= UW'(deny_r);
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      ngx_r[0]  <= negx_r;
      ngy_r[0]  <= negy_r;
      ovx_r[0]  <= UW'(absx_r) >= (UW'(denx_r) << QM);
      ovy_r[0]  <= UW'(absy_r) >= (UW'(deny_r) << QM);
    end
  end

  for (genvar k = 0; k < QM; k++) begin : g_div
    logic [UW-1:0] sdx, sdy;
    logic          gex, gey;

    assign sdx = dnx_r[k] << (QM - 1 - k);
    assign sdy = dny_r[k] << (QM - 1 - k);
    assign gex = remx_r[k] >= sdx;
    assign gey = remy_r[k] >= sdy;

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1]   <= st_r[k];
        remx_r[k+1] <= gex ? remx_r[k] - sdx : remx_r[k];
        remy_r[k+1] <= gey ? remy_r[k] - sdy : remy_r[k];
        dnx_r[k+1]  <= dnx_r[k];
        dny_r[k+1]  <= dny_r[k];
        qx_r[k+1]   <= qx_r[k] | (QM'(gex) << (QM - 1 - k));
        qy_r[k+1]   <= qy_r[k] | (QM'(gey) << (QM - 1 - k));
        ngx_r[k+1]  <= ngx_r[k];
        ngy_r[k+1]  <= ngy_r[k];
        ovx_r[k+1]  <= ovx_r[k];
        ovy_r[k+1]  <= ovy_r[k];
      end
    end
  end

  // Output register. A negative numerator lands on screen only with quotient zero.
  cpp_pkg::status_t          status_r;
  logic [cpp_pkg::PIXEL_X_W-1:0] pixel_x_r;
  logic [cpp_pkg::PIXEL_Y_W-1:0] pixel_y_r;
  logic                      offx, offy;

  assign offx = ovx_r[QM] || (ngx_r[QM] && qx_r[QM] != '0) || (qx_r[QM] >= QW);
  assign offy = ovy_r[QM] || (ngy_r[QM] && qy_r[QM] != '0) || (qy_r[QM] >= QH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (st_r[QM] != cpp_pkg::ST_DRAWN) begin
        status_r  <= st_r[QM];
        pixel_x_r <= '0;
        pixel_y_r <= '0;
      end else if (offx || offy) begin
        status_r  <= cpp_pkg::ST_OFFSCREEN;
        pixel_x_r <= '0;
        pixel_y_r <= '0;
      end else begin
        status_r  <= cpp_pkg::ST_DRAWN;
        pixel_x_r <= cpp_pkg::PIXEL_X_W'(qx_r[QM]);
        pixel_y_r <= cpp_pkg::PIXEL_Y_W'(qy_r[QM]);
      end
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = status_r;
  assign out_ch.pixel_x = pixel_x_r;
  assign out_ch.pixel_y = pixel_y_r;

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != cpp_pkg::ST_DRAWN |-> pixel_x_r == '0 && pixel_y_r == '0)
    else $error("rejected item carries a nonzero pixel");

  a_drawn_in_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == cpp_pkg::ST_DRAWN && SCREEN_WIDTH <= 512
    |-> 32'(pixel_x_r) < SCREEN_WIDTH)
    else $error("drawn item column beyond screen");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(status_r) && $stable(pixel_x_r))
    else $error("stalled result changed");

  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && !en |=> v_r[NST-1])
    else $error("item lost in last stage during stall");

endmodule

// ===== tb/cpp_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench package holding the result record that the checker compares.
// Depends on cpp_pkg.
package cpp_tb_pkg;

  typedef struct packed {
    cpp_pkg::status_t                status;
    logic [cpp_pkg::PIXEL_X_W-1:0]   pixel_x;
    logic [cpp_pkg::PIXEL_Y_W-1:0]   pixel_y;
  } projection_t;
endpackage

// ===== tb/tb_clipped_point_projection_unit.sv =====
`timescale 1ns / 1ps
// Testbench for clipped_point_projection_unit: drives world points with random
// idling, predicts each pixel result and compares it with the block's output.
// Depends on cpp_pkg, cpp_tb_pkg and the three channel interfaces.
module tb_clipped_point_projection_unit;

  localparam int SW = cpp_pkg::SCREEN_WIDTH_DEF;
  localparam int SH = cpp_pkg::SCREEN_HEIGHT_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cpp_in_if  in_ch();
  cpp_out_if out_ch();
  cpp_cfg_if cfg_ch();

  clipped_point_projection_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic [47:0] left_reg, right_reg, cam_reg;
  logic [63:0] rot_reg;
  logic [15:0] focal_reg;

  cpp_tb_pkg::projection_t expected_q[$];
  int errors = 0;
  int points_sent = 0;
  int results_seen = 0;
  int drawn_seen = 0;
  int idle_pct = 28;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic longint sfield(logic [63:0] w, int slot);
    logic signed [15:0] v;
    v = w[16*slot +: 16];
    return longint'(v);
  endfunction

  function automatic logic plane_rejects(logic [47:0] pl, longint px, longint pz);
    longint s;
    s = sfield(pl, 0) * px + sfield(pl, 1) * pz - sfield(pl, 2) * 16384;
    return s < 8192;
  endfunction

  function automatic cpp_tb_pkg::projection_t project_point(logic signed [15:0] x,
                                                            logic signed [15:0] h,
                                                            logic signed [15:0] z);
    cpp_tb_pkg::projection_t res;
    longint px, ph, pz, f, dx, dz, r, d, hy, sx, sy;
    px = x; ph = h; pz = z;
    f = longint'({48'b0, focal_reg});
    res.status = cpp_pkg::ST_DRAWN;
    res.pixel_x = '0;
    res.pixel_y = '0;
    if (plane_rejects(left_reg, px, pz)) begin
      res.status = cpp_pkg::ST_LEFT;
    end else if (plane_rejects(right_reg, px, pz)) begin
      res.status = cpp_pkg::ST_RIGHT;
    end else begin
      dx = px - sfield(cam_reg, 0);
      dz = pz - sfield(cam_reg, 1);
      r = sfield(rot_reg, 0) * dx + sfield(rot_reg, 1) * dz;
      d = sfield(rot_reg, 2) * dx + sfield(rot_reg, 3) * dz;
      if (d <= 0) begin
        res.status = cpp_pkg::ST_BEHIND;
      end else begin
        hy = ph - sfield(cam_reg, 2);
        // SystemVerilog signed division truncates toward zero, as C does.
        sx = (8 * SW * d - f * r) / (16 * d);
        sy = (SH * d - 2048 * f * hy) / (2 * d);
        if (sx >= 0 && sx < SW && sy >= 0 && sy < SH) begin
          res.pixel_x = sx[cpp_pkg::PIXEL_X_W-1:0];
          res.pixel_y = sy[cpp_pkg::PIXEL_Y_W-1:0];
        end else begin
          res.status = cpp_pkg::ST_OFFSCREEN;
        end
      end
    end
    return res;
  endfunction

  task automatic write_reg(cpp_pkg::reg_idx_t idx, logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      cpp_pkg::REG_LEFT_PLANE:  left_reg  = value[47:0];
      cpp_pkg::REG_RIGHT_PLANE: right_reg = value[47:0];
      cpp_pkg::REG_ROTATION:    rot_reg   = value;
      cpp_pkg::REG_CAMERA_POS:  cam_reg   = value[47:0];
      cpp_pkg::REG_FOCAL_DIST:  focal_reg = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] h,
                            logic signed [15:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.point_x <= x;
    in_ch.point_height <= h;
    in_ch.point_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(project_point(x, h, z));
    points_sent++;
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    // Zero planes reject everything on the left test.
    send_point(16'sh0000, 16'sh0000, 16'sh0000);
    send_point(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_point(16'sh8000, 16'sh7fff, 16'sh8000);
    end_burst();
    drain();
  endtask

  task automatic test_directed();
    // Planes with zero normal and distance -32768 pass every point.
    write_reg(cpp_pkg::REG_LEFT_PLANE,  {16'sh8000, 16'h0000, 16'h0000});
    write_reg(cpp_pkg::REG_RIGHT_PLANE, {16'sh8000, 16'h0000, 16'h0000});
    send_point(16'sh0000, 16'sh0000, 16'sh0100);
    send_point(16'sh0010, 16'shfff0, 16'sh0100);
    send_point(16'sh0000, 16'sh0000, 16'sh0000);
    send_point(16'sh0000, 16'sh0000, 16'shff00);
    send_point(16'sh7fff, 16'sh7fff, 16'sh0001);
    send_point(16'sh8000, 16'sh8000, 16'sh7fff);
    send_point(16'sh0040, 16'sh0000, 16'sh0010);
    end_burst();
    drain();
    // Left plane only: normal +x, so points at negative x clip left.
    write_reg(cpp_pkg::REG_LEFT_PLANE, {16'h0000, 16'h0000, 16'h4000});
    send_point(16'shff00, 16'sh0000, 16'sh0100);
    send_point(16'sh0100, 16'sh0000, 16'sh0100);
    end_burst();
    drain();
    // Right plane rejects; left then passes. Both failing must report left.
    write_reg(cpp_pkg::REG_RIGHT_PLANE, {16'h0000, 16'h0000, 16'hc000});
    send_point(16'sh0100, 16'sh0000, 16'sh0100);
    end_burst();
    drain();
    write_reg(cpp_pkg::REG_LEFT_PLANE, 48'h0);
    send_point(16'sh0100, 16'sh0000, 16'sh0100);
    end_burst();
    drain();
    // Focal distance of zero sends every visible point to the center.
    write_reg(cpp_pkg::REG_LEFT_PLANE,  {16'sh8000, 16'h0000, 16'h0000});
    write_reg(cpp_pkg::REG_RIGHT_PLANE, {16'sh8000, 16'h0000, 16'h0000});
    write_reg(cpp_pkg::REG_FOCAL_DIST, 64'h0);
    send_point(16'sh1234, 16'sh7fff, 16'sh0200);
    end_burst();
    drain();
    write_reg(cpp_pkg::REG_FOCAL_DIST, 64'hffff_ffff_ffff_ffff);
    send_point(16'sh0000, 16'sh0000, 16'sh7fff);
    end_burst();
    drain();
    write_reg(cpp_pkg::REG_FOCAL_DIST, 64'd16);
    write_reg(cpp_pkg::REG_CAMERA_POS, {16'sh0010, 16'shff00, 16'sh0020});
    write_reg(cpp_pkg::REG_ROTATION, {16'sh4000, 16'sh0000, 16'sh0000, 16'shc000});
    send_point(16'sh0000, 16'sh0000, 16'sh0000);
    send_point(16'sh0100, 16'sh0020, 16'sh0100);
    end_burst();
    drain();
    write_reg(cpp_pkg::REG_ROTATION, 64'h8000_7fff_8000_7fff);
    write_reg(cpp_pkg::REG_CAMERA_POS, 64'hffff_ffff_ffff_ffff);
    send_point(16'sh0100, 16'sh0000, 16'sh0100);
    end_burst();
    drain();
    // Unknown register index must leave every register unchanged.
    write_reg(cpp_pkg::reg_idx_t'(3'd7), 64'h0123_4567_89ab_cdef);
    write_reg(cpp_pkg::reg_idx_t'(3'd5), 64'h0);
    send_point(16'sh0100, 16'sh0000, 16'sh0100);
    end_burst();
    drain();
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      default: return 16'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  task automatic random_setting();
    logic [15:0] c, s;
    c = 16'($urandom_range(16384));
    s = 16'($urandom_range(16384) - 8192);
    write_reg(cpp_pkg::REG_LEFT_PLANE, {16'($urandom_range(64)) - 16'd32, 16'h3000,
                                        16'h2c00 + 16'($urandom_range(2048))});
    write_reg(cpp_pkg::REG_RIGHT_PLANE, {16'($urandom_range(64)) - 16'd32, 16'h3000,
                                         16'hd400 - 16'($urandom_range(2048))});
    write_reg(cpp_pkg::REG_ROTATION, {c, 16'(-$signed(s)), s, c});
    write_reg(cpp_pkg::REG_CAMERA_POS, {16'($urandom_range(64)) - 16'd32,
                                        16'($urandom_range(64)) - 16'd32,
                                        16'($urandom_range(64)) - 16'd32});
    write_reg(cpp_pkg::REG_FOCAL_DIST, 64'($urandom_range(16, 4000)));
  endtask

  task automatic test_random();
    for (int blk = 0; blk < 8; blk++) begin
      if (blk == 7) begin
        write_reg(cpp_pkg::REG_LEFT_PLANE, 64'($urandom) << 16 | 64'($urandom));
        write_reg(cpp_pkg::REG_RIGHT_PLANE, {$urandom, $urandom});
        write_reg(cpp_pkg::REG_ROTATION, {$urandom, $urandom});
        write_reg(cpp_pkg::REG_CAMERA_POS, {$urandom, $urandom});
        write_reg(cpp_pkg::REG_FOCAL_DIST, 64'($urandom));
      end else begin
        random_setting();
      end
      // One block runs with no idling at all.
      idle_pct = (blk == 3) ? 0 : 28;
      for (int i = 0; i < 45; i++) begin
        send_point(rand_coord(), rand_coord(), rand_coord());
      end
      end_burst();
      drain();
    end
    idle_pct = 28;
  endtask

  task automatic test_backpressure();
    random_setting();
    // The receiver holds off for a long stretch while points keep coming.
    hold_req++;
    for (int i = 0; i < 40; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    end_burst();
    drain();
  endtask

  // Result checker.
  always @(posedge clk) begin
    cpp_tb_pkg::projection_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.pixel_x = out_ch.pixel_x;
      got.pixel_y = out_ch.pixel_y;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d x=%0d y=%0d", $time,
                 got.status, got.pixel_x, got.pixel_y);
      end else begin
        want = expected_q.pop_front();
        if (want.status == cpp_pkg::ST_DRAWN) drawn_seen++;
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.pixel_x !== want.pixel_x) begin
          errors++;
          $display("%0t: pixel_x expected %0d actual %0d", $time, want.pixel_x,
                   got.pixel_x);
        end
        if (got.pixel_y !== want.pixel_y) begin
          errors++;
          $display("%0t: pixel_y expected %0d actual %0d", $time, want.pixel_y,
                   got.pixel_y);
        end
      end
    end
  end

  // Receiver idling, including the long hold that the test requests.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n || hold_left > 0) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("** clipped_point_projection_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_height = '0;
    in_ch.point_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    left_reg = cpp_pkg::LEFT_PLANE_RST;
    right_reg = cpp_pkg::RIGHT_PLANE_RST;
    rot_reg = cpp_pkg::ROTATION_RST;
    cam_reg = cpp_pkg::CAMERA_POS_RST;
    focal_reg = cpp_pkg::FOCAL_DIST_RST;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_directed();
    test_random();
    test_backpressure();
    $display("Sent %0d points, checked %0d results (%0d drawn) over several setups.",
             points_sent, results_seen, drawn_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** clipped_point_projection_unit: PASSED **");
    end else begin
      $display("** clipped_point_projection_unit: FAILED **");
    end
    $finish;
  end
endmodule
